// ===== design/utts_pkg.sv =====
// ----------------------------------------------------------------------------
// utts_pkg: shared types and helpers for the utf-16 to utf-8 stream unit
// Job record passed from the classifier to the byte emitter, queue sizing,
// and the utf-8 byte builder.
// ----------------------------------------------------------------------------
package utts_pkg;

   // queue between classifier and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // positions inside the result tuser bus
   localparam int USER_HAS_BYTE   = 0;
   localparam int USER_ERROR      = 1;
   localparam int USER_STRING_END = 2;
   localparam int USER_W          = 3;

   // number of bytes in the utf-8 form, minus one
   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   // one unit of work for the emitter
   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  last_idx;    // byte count minus one
      logic        err;         // emit one error result instead of bytes
      logic        is_last;     // last unit of the string
   } job_type;

   // byte idx of the utf-8 encoding of code point cp, of length last_idx+1
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [1:0]  last_idx,
                                            input logic [1:0]  idx);
      logic [7:0] b;
      b = 8'h00;
      case (last_idx)
         LEN_ONE: b = {1'b0, cp[6:0]};
         LEN_TWO: begin
            case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         LEN_THREE: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// ===== design/utts_front.sv =====
// ----------------------------------------------------------------------------
// utts_front: code unit classifier
// Accepts utf-16 code units, pairs surrogates, tracks failed strings and
// pushes one job per code point or error into the queue.
// ----------------------------------------------------------------------------
module utts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [15:0] code_unit
   input  logic              req_tlast,   // is_last
   input  logic              queue_full,
   output logic              push,
   output utts_pkg::job_type push_job
);

   logic [9:0] held_high_ff, held_high_in;
   logic       high_pending_ff, high_pending_in;
   logic       string_failed_ff, string_failed_in;
   logic       accept;
   logic       is_high;
   logic       is_low;
   logic [20:0] supp_cp;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = (req_tdata[15:10] == 6'b110110);
   assign is_low     = (req_tdata[15:10] == 6'b110111);
   assign supp_cp    = {1'b0, held_high_ff, req_tdata[9:0]} + 21'h10000;

   // classify the unit and work out the next surrogate state
   always_comb begin
      held_high_in       = held_high_ff;
      high_pending_in    = high_pending_ff;
      string_failed_in   = string_failed_ff;
      push               = 1'b0;
      push_job.code_point = {5'd0, req_tdata};
      push_job.last_idx  = utts_pkg::LEN_ONE;
      push_job.err       = 1'b0;
      push_job.is_last   = req_tlast;
      if (accept) begin
         if (string_failed_ff) begin
            string_failed_in = !req_tlast;
         end else if (high_pending_ff) begin
            push            = 1'b1;
            high_pending_in = 1'b0;
            held_high_in    = 10'd0;
            if (!is_low) begin
               push_job.err     = 1'b1;
               string_failed_in = !req_tlast;
            end else begin
               push_job.code_point = supp_cp;
               push_job.last_idx   = utts_pkg::LEN_FOUR;
            end
         end else if (is_high) begin
            if (req_tlast) begin
               push         = 1'b1;
               push_job.err = 1'b1;
            end else begin
               held_high_in    = req_tdata[9:0];
               high_pending_in = 1'b1;
            end
         end else if (is_low) begin
            push             = 1'b1;
            push_job.err     = 1'b1;
            string_failed_in = !req_tlast;
         end else begin
            push = 1'b1;
            if (req_tdata < 16'h0080) begin
               push_job.last_idx = utts_pkg::LEN_ONE;
            end else if (req_tdata < 16'h0800) begin
               push_job.last_idx = utts_pkg::LEN_TWO;
            end else begin
               push_job.last_idx = utts_pkg::LEN_THREE;
            end
         end
      end
   end

   // surrogate and failure state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_ff     <= 10'd0;
         high_pending_ff  <= 1'b0;
         string_failed_ff <= 1'b0;
      end else begin
         held_high_ff     <= held_high_in;
         high_pending_ff  <= high_pending_in;
         string_failed_ff <= string_failed_in;
      end
   end

endmodule

// ===== design/utts_queue.sv =====
// ----------------------------------------------------------------------------
// utts_queue: job queue
// Small show-ahead queue of jobs between the classifier and the emitter.
// ----------------------------------------------------------------------------
module utts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utts_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output utts_pkg::job_type head_job,
   output logic [utts_pkg::QCNT_W-1:0] level
);

   utts_pkg::job_type                entry_ff [utts_pkg::QUEUE_DEPTH];
   logic [utts_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [utts_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [utts_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = (count_ff == utts_pkg::QCNT_W'(utts_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];
   assign level    = count_ff;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + utts_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + utts_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + utts_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - utts_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/utts_back.sv =====
// ----------------------------------------------------------------------------
// utts_back: byte emitter
// Walks the job at the queue head one byte per cycle into the result
// register while free, and pops the job after its last byte or error result.
// ----------------------------------------------------------------------------
module utts_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  utts_pkg::job_type            head_job,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [7:0] out_byte
   output logic                         rsp_tlast,  // run_last
   output logic [utts_pkg::USER_W-1:0]  rsp_tuser   // [0] has_byte, [1] error,
                                                    // [2] string_end
);

   logic [1:0]                      idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   logic [7:0]                      byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic [utts_pkg::USER_W-1:0]     user_ff, user_in;
   logic                            slot_free;
   logic                            load;
   logic                            final_byte;

   assign slot_free  = !valid_ff || rsp_tready;
   assign load       = slot_free && !queue_empty;
   assign final_byte = head_job.err || (idx_ff == head_job.last_idx);
   assign pop        = load && final_byte;

   // next result and byte index
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (slot_free) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in  = final_byte;
         user_in[utts_pkg::USER_ERROR]      = head_job.err;
         user_in[utts_pkg::USER_HAS_BYTE]   = !head_job.err;
         user_in[utts_pkg::USER_STRING_END] = final_byte &&
                                              (head_job.err || head_job.is_last);
         if (head_job.err) begin
            byte_in = 8'h00;
         end else begin
            byte_in = utts_pkg::utf8_byte(head_job.code_point, head_job.last_idx,
                                          idx_ff);
         end
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ===== design/utf16_to_utf8_stream_unit.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_stream_unit: utf-16 to utf-8 stream converter
// Turns a stream of utf-16 code units into utf-8 bytes, one byte per result
// transfer, with error results for broken surrogate sequences.
//
//   channel  dir  data                    side band
//   req_     in   code_unit [15:0]        tlast = is_last
//   rsp_     out  out_byte [7:0]          tlast = run_last,
//                                         tuser = has_byte, error, string_end
//
// A code unit is accepted while the job queue has room; a failed-string
// item or a held high surrogate yields no job, and the low half of a
// surrogate pair yields one four-byte job. The emitter sends one result per
// cycle while the queue is not empty and the output is not stalled: one
// result per utf-8 byte of a job, or one for an error job. Reset is
// synchronous and clears the surrogate state, queue and result valid flag. A
// stalled result holds while the queue keeps accepting input until it fills.
// ----------------------------------------------------------------------------
module utf16_to_utf8_stream_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,  // [15:0] code_unit
   input  logic                         req_tlast,  // is_last
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [7:0] out_byte
   output logic                         rsp_tlast,  // run_last
   output logic [utts_pkg::USER_W-1:0]  rsp_tuser   // [0] has_byte, [1] error,
                                                    // [2] string_end
);

   utts_pkg::job_type               push_job;
   utts_pkg::job_type               head_job;
   logic                            push;
   logic                            pop;
   logic                            queue_full;
   logic                            queue_empty;
   logic [utts_pkg::QCNT_W-1:0]     queue_level;

   // classifier
   utts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // job queue
   utts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job),
      .level    (queue_level)
   );

   // byte emitter
   utts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

`ifndef SYNTHESIS
   // an error result is always a complete run and ends its string
   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[utts_pkg::USER_ERROR] |->
         rsp_tlast && rsp_tuser[utts_pkg::USER_STRING_END] &&
         !rsp_tuser[utts_pkg::USER_HAS_BYTE])
      else $error("error result without run and string end");

   // end of string only on the last result of a run
   a_end_on_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[utts_pkg::USER_STRING_END] |-> rsp_tlast)
      else $error("string end on a result that is not last of its run");

   // queue never pushed when full and never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_level <= utts_pkg::QCNT_W'(utts_pkg::QUEUE_DEPTH) &&
      !(push && queue_full))
      else $error("job queue overflow");
`endif

endmodule
